@@ rtl/vbsp_pkg.sv @@
// Package for the voice-file block stream parser.
// Holds result kind codes, the rate dividend and the control/status structs.
// No dependencies.
package vbsp_pkg;

    localparam int unsigned  RATE_W        = 20;
    localparam int unsigned  RATE_STEP_W   = 5;
    localparam int unsigned  DIVISOR_W     = 9;
    localparam int unsigned  LEN_W         = 24;
    localparam logic [RATE_W-1:0] RATE_DIVIDEND = 20'd1000000;
    localparam logic [DIVISOR_W-1:0] TC_BASE = 9'd256;

    localparam logic [1:0] KIND_SAMPLE = 2'd0;
    localparam logic [1:0] KIND_RATE   = 2'd1;
    localparam logic [1:0] KIND_END    = 2'd2;

    localparam logic [7:0] BLK_SOUND    = 8'd1;
    localparam logic [7:0] BLK_CONTINUE = 8'd2;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic start_block;
        logic load_len;
        logic count_body;
        logic start_div;
        logic emit_sample;
        logic emit_end;
        logic emit_rate;
    } vbsp_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic byte_zero;
        logic len_last;
        logic len_zero;
        logic blk_sound;
        logic blk_continue;
        logic left_one;
        logic left_zero;
        logic div_done;
        logic out_busy;
    } vbsp_stat_t;

endpackage

@@ rtl/vbsp_div.sv @@
// Bit-serial restoring divider: fixed dividend 1000000 over a 9-bit divisor.
// One quotient bit per cycle. Depends on vbsp_pkg.
module vbsp_div (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                start,
    input  logic [vbsp_pkg::DIVISOR_W-1:0]      divisor,
    output logic                                done,
    output logic [vbsp_pkg::RATE_W-1:0]         quotient
);

    logic                                busy_reg, busy_next;
    logic                                done_reg, done_next;
    logic [vbsp_pkg::RATE_STEP_W-1:0]    idx_reg, idx_next;
    logic [vbsp_pkg::DIVISOR_W-1:0]      div_reg, div_next;
    logic [vbsp_pkg::DIVISOR_W-1:0]      rem_reg, rem_next;
    logic [vbsp_pkg::RATE_W-1:0]         quo_reg, quo_next;
    logic [vbsp_pkg::DIVISOR_W:0]        trial;
    logic [vbsp_pkg::DIVISOR_W:0]        diff;
    logic                                ge;

    // Trial subtraction for the current dividend bit
    assign trial = {rem_reg, vbsp_pkg::RATE_DIVIDEND[idx_reg]};
    assign ge    = (trial >= {1'b0, div_reg});
    assign diff  = trial - {1'b0, div_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        idx_next  = idx_reg;
        div_next  = div_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        if (start) begin
            busy_next = 1'b1;
            idx_next  = vbsp_pkg::RATE_STEP_W'(vbsp_pkg::RATE_W - 1);
            div_next  = divisor;
            rem_next  = '0;
            quo_next  = '0;
        end else if (busy_reg) begin
            rem_next = ge ? diff[vbsp_pkg::DIVISOR_W-1:0] : trial[vbsp_pkg::DIVISOR_W-1:0];
            quo_next = {quo_reg[vbsp_pkg::RATE_W-2:0], ge};
            if (idx_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                idx_next = idx_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        idx_reg <= idx_next;
        div_reg <= div_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

@@ rtl/vbsp_dp.sv @@
// Datapath: block type and length registers, body counter, rate divider
// and the result register. Depends on vbsp_pkg and vbsp_div.
module vbsp_dp (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic [7:0]                data_byte,
    input  vbsp_pkg::vbsp_cmd_t       cmd,
    output vbsp_pkg::vbsp_stat_t      stat,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [1:0]                m_kind,
    output logic signed [15:0]        m_sample,
    output logic [vbsp_pkg::RATE_W-1:0] m_rate_hz
);

    logic [7:0]                      blk_reg, blk_next;
    logic [vbsp_pkg::LEN_W-1:0]      left_reg, left_next;
    logic [1:0]                      idx_reg, idx_next;
    logic [vbsp_pkg::LEN_W-1:0]      len_merged;
    logic                            valid_reg, valid_next;
    logic [1:0]                      kind_reg, kind_next;
    logic signed [15:0]              sample_reg, sample_next;
    logic [vbsp_pkg::RATE_W-1:0]     rate_reg, rate_next;
    logic                            div_done;
    logic [vbsp_pkg::RATE_W-1:0]     div_quo;
    logic [vbsp_pkg::DIVISOR_W-1:0]  divisor;

    // Merge the incoming length byte at its little-endian position
    always_comb begin
        unique case (idx_reg)
            2'd0:    len_merged = left_reg | {16'h0000, data_byte};
            2'd1:    len_merged = left_reg | {8'h00, data_byte, 8'h00};
            2'd2:    len_merged = left_reg | {data_byte, 16'h0000};
            default: len_merged = left_reg;
        endcase
    end

    // Block header and body count
    always_comb begin
        blk_next  = blk_reg;
        left_next = left_reg;
        idx_next  = idx_reg;
        if (cmd.start_block) begin
            blk_next  = data_byte;
            left_next = '0;
            idx_next  = '0;
        end else if (cmd.load_len) begin
            left_next = len_merged;
            idx_next  = (idx_reg == 2'd2) ? 2'd0 : idx_reg + 2'd1;
        end else if (cmd.count_body) begin
            left_next = left_reg - 1'b1;
        end
    end

    assign divisor = vbsp_pkg::TC_BASE - {1'b0, data_byte};

    vbsp_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.start_div),
        .divisor  (divisor),
        .done     (div_done),
        .quotient (div_quo)
    );

    // Result register: load on emit, drop valid once the transfer completes
    always_comb begin
        valid_next  = valid_reg && !m_ready;
        kind_next   = kind_reg;
        sample_next = sample_reg;
        rate_next   = rate_reg;
        if (cmd.emit_sample) begin
            valid_next  = 1'b1;
            kind_next   = vbsp_pkg::KIND_SAMPLE;
            sample_next = {~data_byte[7], data_byte[6:0], 8'h00};
            rate_next   = '0;
        end else if (cmd.emit_end) begin
            valid_next  = 1'b1;
            kind_next   = vbsp_pkg::KIND_END;
            sample_next = '0;
            rate_next   = '0;
        end else if (cmd.emit_rate) begin
            valid_next  = 1'b1;
            kind_next   = vbsp_pkg::KIND_RATE;
            sample_next = '0;
            rate_next   = div_quo;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            blk_reg   <= '0;
            left_reg  <= '0;
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            blk_reg   <= blk_next;
            left_reg  <= left_next;
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
        kind_reg   <= kind_next;
        sample_reg <= sample_next;
        rate_reg   <= rate_next;
    end

    // Status back to the controller
    always_comb begin
        stat.byte_zero    = (data_byte == 8'h00);
        stat.len_last     = (idx_reg == 2'd2);
        stat.len_zero     = (len_merged == '0);
        stat.blk_sound    = (blk_reg == vbsp_pkg::BLK_SOUND);
        stat.blk_continue = (blk_reg == vbsp_pkg::BLK_CONTINUE);
        stat.left_one     = (left_reg == vbsp_pkg::LEN_W'(1));
        stat.left_zero    = (left_reg == '0);
        stat.div_done     = div_done;
        stat.out_busy     = valid_reg && !m_ready;
    end

    assign m_valid   = valid_reg;
    assign m_kind    = kind_reg;
    assign m_sample  = sample_reg;
    assign m_rate_hz = rate_reg;

endmodule

@@ rtl/vbsp_ctrl.sv @@
// Controller: block parsing state machine driving the datapath.
// Depends on vbsp_pkg.
module vbsp_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  vbsp_pkg::vbsp_stat_t  stat,
    output vbsp_pkg::vbsp_cmd_t   cmd
);

    typedef enum logic [7:0] {
        S_TYPE = 8'b0000_0001,
        S_LEN  = 8'b0000_0010,
        S_TC   = 8'b0000_0100,
        S_DIV  = 8'b0000_1000,
        S_PACK = 8'b0001_0000,
        S_DATA = 8'b0010_0000,
        S_SKIP = 8'b0100_0000,
        S_DONE = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   accept;

    // Stall input while dividing or while the result register cannot drain
    assign s_ready = (state_reg != S_DIV) && !stat.out_busy;
    assign accept  = s_valid && s_ready;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_TYPE: begin
                if (accept) begin
                    if (stat.byte_zero) begin
                        cmd.emit_end = 1'b1;
                        state_next   = S_DONE;
                    end else begin
                        cmd.start_block = 1'b1;
                        state_next      = S_LEN;
                    end
                end
            end
            S_LEN: begin
                if (accept) begin
                    cmd.load_len = 1'b1;
                    if (stat.len_last) begin
                        priority if (stat.len_zero)     state_next = S_TYPE;
                        else if (stat.blk_sound)        state_next = S_TC;
                        else if (stat.blk_continue)     state_next = S_DATA;
                        else                            state_next = S_SKIP;
                    end
                end
            end
            S_TC: begin
                if (accept) begin
                    cmd.start_div  = 1'b1;
                    cmd.count_body = 1'b1;
                    state_next     = S_DIV;
                end
            end
            S_DIV: begin
                if (stat.div_done) begin
                    cmd.emit_rate = 1'b1;
                    state_next    = stat.left_zero ? S_TYPE : S_PACK;
                end
            end
            S_PACK: begin
                if (accept) begin
                    cmd.count_body = 1'b1;
                    state_next     = stat.left_one ? S_TYPE : S_DATA;
                end
            end
            S_DATA: begin
                if (accept) begin
                    cmd.emit_sample = 1'b1;
                    cmd.count_body  = 1'b1;
                    state_next      = stat.left_one ? S_TYPE : S_DATA;
                end
            end
            S_SKIP: begin
                if (accept) begin
                    cmd.count_body = 1'b1;
                    state_next     = stat.left_one ? S_TYPE : S_SKIP;
                end
            end
            S_DONE: begin
                // drop every byte after the end block
                state_next = S_DONE;
            end
            default: begin
                state_next = S_TYPE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_TYPE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

@@ rtl/voc_block_stream_parser_core.sv @@
// Top level of the voice-file block stream parser.
// Depends on vbsp_pkg, vbsp_ctrl, vbsp_dp (which holds vbsp_div).
//
// Takes the block area of an 8-bit PCM voice file one byte per transfer and
// emits samples, sample-rate changes and an end marker. A result sits in an
// output register, so the next byte is taken in the cycle the result leaves.
// A time-constant byte of a sound block starts the bit-serial rate divider
// (one quotient bit per cycle), and s_ready stays low until the quotient is
// done and the rate result is loaded. After an end block every byte is
// accepted and dropped until reset.
module voc_block_stream_parser_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [7:0]                    s_data_byte,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [1:0]                    m_kind,
    output logic signed [15:0]            m_sample,
    output logic [vbsp_pkg::RATE_W-1:0]   m_rate_hz
);

    vbsp_pkg::vbsp_cmd_t  cmd;
    vbsp_pkg::vbsp_stat_t stat;

    vbsp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    vbsp_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .data_byte (s_data_byte),
        .cmd       (cmd),
        .stat      (stat),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_kind    (m_kind),
        .m_sample  (m_sample),
        .m_rate_hz (m_rate_hz)
    );

endmodule
